### design/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants, codes and controller/datapath handshake types for the
// binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // Heap geometry
  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CHD_W     = IDX_W + 2;
  localparam int OUT_CNT_W = 7;
  localparam int STAT_W    = 2;

  // Operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Ordering modes
  localparam logic MODE_MAX = 1'b0;

  // Read port address selection
  typedef enum logic [1:0] {
    RD_PARENT = 2'd0,
    RD_POPSRC = 2'd1,
    RD_CHILD  = 2'd2,
    RD_ROOT   = 2'd3
  } rd_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load_item;
    logic    set_full;
    logic    set_empty;
    logic    begin_push;
    logic    begin_pop;
    rd_sel_t rd_sel;
    logic    wr_hole;
    logic    up_step;
    logic    pop_load;
    logic    dn_step;
    logic    load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic pos_root;
    logic up_move;
    logic dn_move;
    logic leaf;
  } ctl_stat_t;

  // True when a must sit above b under the selected ordering
  function automatic logic outranks(logic signed [DATA_W-1:0] a,
                                    logic signed [DATA_W-1:0] b,
                                    logic mode);
    logic res;
    if (mode == MODE_MAX) begin
      res = (a > b);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

### design/bhpq_in_if.sv
// ----------------------------------------------------------------------------
// bhpq_in_if
// Request channel: one push or pop command per transaction.
// ----------------------------------------------------------------------------
interface bhpq_in_if;
  import bhpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

### design/bhpq_out_if.sv
// ----------------------------------------------------------------------------
// bhpq_out_if
// Result channel: status, removed entry, new top and fill level.
// ----------------------------------------------------------------------------
interface bhpq_out_if;
  import bhpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] removed_value;
  logic signed [DATA_W-1:0] top_value;
  logic                     heap_empty;
  logic [OUT_CNT_W-1:0]     entry_count;

  modport source (output valid, output status, output removed_value, output top_value,
                  output heap_empty, output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input top_value,
                  input heap_empty, input entry_count, output ready);
endinterface

### design/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap of signed 32-bit entries, max-heap or min-heap by mode bit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transaction: push value, or pop the top.
//   out_ch returns exactly one result per command: status, removed entry,
//   new top, empty flag and entry count after the operation.
//   cfg_wr_en/cfg_wr_data write the ordering mode (0 max-heap, 1 min-heap);
//   write it only while no command is in flight. Stored entries are not
//   reordered by a mode change.
// Sequencing:
//   One command is in flight at a time. A push climbs from the new last
//   slot toward the root; a pop moves the last entry to the root and sinks
//   it toward a leaf, or skips the walk when it takes the last entry. The
//   entry moves at most 6 levels up, 5 down for 64 entries. Each level is a
//   memory read step and then a compare-and-write step. Full or empty
//   errors skip the walk and go on to the root read.
// Reset and back-pressure:
//   Reset empties the heap and selects max-heap. The result sits in an output
//   register; the next command is accepted while it waits, and its own result
//   is held back until the previous one has been taken.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  bhpq_in_if.sink    in_ch,
  bhpq_out_if.source out_ch
);
  import bhpq_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_ready, out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // Sequencer
  bhpq_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, compares and result register
  bhpq_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_command        (in_ch.command),
    .in_value          (in_ch.value),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_ch.status),
    .out_removed_value (out_ch.removed_value),
    .out_top_value     (out_ch.top_value),
    .out_heap_empty    (out_ch.heap_empty),
    .out_entry_count   (out_ch.entry_count)
  );

endmodule

### design/bhpq_datapath.sv
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory with two registered read ports, the moving entry, hole
// position, fill count, ordering mode, compare logic and result register.
// ----------------------------------------------------------------------------
module bhpq_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_command,
  input  logic signed [bhpq_pkg::DATA_W-1:0] in_value,
  input  bhpq_pkg::ctl_cmd_t                 cmd,
  output bhpq_pkg::ctl_stat_t                stat,
  output logic [bhpq_pkg::STAT_W-1:0]        out_status,
  output logic signed [bhpq_pkg::DATA_W-1:0] out_removed_value,
  output logic signed [bhpq_pkg::DATA_W-1:0] out_top_value,
  output logic                               out_heap_empty,
  output logic [bhpq_pkg::OUT_CNT_W-1:0]     out_entry_count
);
  import bhpq_pkg::*;

  // Heap storage and read data
  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;

  // Item and walk state
  logic                     cmd_r;
  logic signed [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     mode_r;
  logic [STAT_W-1:0]        code_r;
  logic signed [DATA_W-1:0] removed_r;

  // Result register
  logic [STAT_W-1:0]        res_status_r;
  logic signed [DATA_W-1:0] res_removed_r, res_top_r;
  logic                     res_empty_r;
  logic [OUT_CNT_W-1:0]     res_count_r;

  // Combinational helpers
  logic [IDX_W-1:0]         parent_idx;
  logic [CHD_W-1:0]         l_idx, r_idx, count_ext;
  logic                     r_ok, l_win, r_win, up_move, dn_move;
  logic signed [DATA_W-1:0] cand_val, best_val, wr_data;
  logic [IDX_W-1:0]         best_idx, addr_a, addr_b;
  logic                     wr_en;

  // Neighbor indexes and compares
  always_comb begin
    parent_idx = (pos_r - IDX_W'(1)) >> 1;
    l_idx      = (CHD_W'(pos_r) << 1) + CHD_W'(1);
    r_idx      = (CHD_W'(pos_r) << 1) + CHD_W'(2);
    count_ext  = CHD_W'(count_r);
    r_ok       = (r_idx < count_ext);
    up_move    = outranks(val_r, rd_a_r, mode_r);
    l_win      = outranks(rd_a_r, val_r, mode_r);
    cand_val   = l_win ? rd_a_r : val_r;
    r_win      = r_ok && outranks(rd_b_r, cand_val, mode_r);
    dn_move    = l_win || r_win;
    best_idx   = r_win ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
    best_val   = r_win ? rd_b_r : rd_a_r;
  end

  // Status toward the controller
  always_comb begin
    stat.is_pop   = (cmd_r == CMD_POP);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.empty    = (count_r == '0);
    stat.pos_root = (pos_r == '0);
    stat.up_move  = up_move;
    stat.dn_move  = dn_move;
    stat.leaf     = !(l_idx < count_ext);
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_PARENT: begin
        addr_a = parent_idx;
        addr_b = '0;
      end
      RD_POPSRC: begin
        addr_a = '0;
        addr_b = count_r[IDX_W-1:0];
      end
      RD_CHILD: begin
        addr_a = l_idx[IDX_W-1:0];
        addr_b = r_idx[IDX_W-1:0];
      end
      RD_ROOT: begin
        addr_a = '0;
        addr_b = '0;
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Write into the hole: a promoted neighbor, or the moving entry to settle
  always_comb begin
    wr_en   = cmd.wr_hole || cmd.up_step || cmd.dn_step;
    wr_data = val_r;
    if (cmd.up_step && up_move) begin
      wr_data = rd_a_r;
    end else if (cmd.dn_step && dn_move) begin
      wr_data = best_val;
    end
  end

  // Heap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Hole position and fill count
  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    if (cmd.begin_push) begin
      pos_nxt   = count_r[IDX_W-1:0];
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.begin_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.up_step && up_move) begin
      pos_nxt = parent_idx;
    end else if (cmd.pop_load) begin
      pos_nxt = '0;
    end else if (cmd.dn_step && dn_move) begin
      pos_nxt = best_idx;
    end
  end

  // Control state: fill count and ordering mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= MODE_MAX;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  // Item payload, walk registers and result register
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (cmd.load_item) begin
      cmd_r     <= in_command;
      val_r     <= in_value;
      code_r    <= ST_OK;
      removed_r <= '0;
    end
    if (cmd.set_full) begin
      code_r <= ST_FULL;
    end
    if (cmd.set_empty) begin
      code_r <= ST_EMPTY;
    end
    if (cmd.pop_load) begin
      removed_r <= rd_a_r;
      val_r     <= rd_b_r;
    end
    if (cmd.load_out) begin
      res_status_r  <= code_r;
      res_removed_r <= removed_r;
      res_top_r     <= (count_r == '0) ? '0 : rd_a_r;
      res_empty_r   <= (count_r == '0);
      res_count_r   <= OUT_CNT_W'(count_r);
    end
  end

  assign out_status        = res_status_r;
  assign out_removed_value = res_removed_r;
  assign out_top_value     = res_top_r;
  assign out_heap_empty    = res_empty_r;
  assign out_entry_count   = res_count_r;

endmodule

### design/bhpq_controller.sv
// ----------------------------------------------------------------------------
// bhpq_controller
// Sequencer for one transaction at a time: checks, sift-up or sift-down
// walk, root read and hand-off to the result register.
// ----------------------------------------------------------------------------
module bhpq_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bhpq_pkg::ctl_stat_t stat,
  output bhpq_pkg::ctl_cmd_t  cmd
);
  import bhpq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CHECK   = 10'b00_0000_0010,
    S_UP_RD   = 10'b00_0000_0100,
    S_UP_CMP  = 10'b00_0000_1000,
    S_POP_RD  = 10'b00_0001_0000,
    S_POP_LD  = 10'b00_0010_0000,
    S_DN_RD   = 10'b00_0100_0000,
    S_DN_CMP  = 10'b00_1000_0000,
    S_ROOT_RD = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_ROOT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_pop) begin
          if (stat.empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = S_ROOT_RD;
          end else begin
            cmd.begin_pop = 1'b1;
            state_nxt     = S_POP_RD;
          end
        end else begin
          if (stat.full) begin
            cmd.set_full = 1'b1;
            state_nxt    = S_ROOT_RD;
          end else begin
            cmd.begin_push = 1'b1;
            state_nxt      = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (stat.pos_root) begin
          cmd.wr_hole = 1'b1;
          state_nxt   = S_ROOT_RD;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        state_nxt   = stat.up_move ? S_UP_RD : S_ROOT_RD;
      end
      S_POP_RD: begin
        cmd.rd_sel = RD_POPSRC;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = stat.empty ? S_ROOT_RD : S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.leaf) begin
          cmd.wr_hole = 1'b1;
          state_nxt   = S_ROOT_RD;
        end else begin
          cmd.rd_sel = RD_CHILD;
          state_nxt  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        state_nxt   = stat.dn_move ? S_DN_RD : S_ROOT_RD;
      end
      S_ROOT_RD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until taken; load a new one when the slot frees up
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks on the heap queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bhpq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bhpq_pkg::STAT_W-1:0]        status,
  input logic signed [bhpq_pkg::DATA_W-1:0] removed_value,
  input logic signed [bhpq_pkg::DATA_W-1:0] top_value,
  input logic                               heap_empty,
  input logic [bhpq_pkg::OUT_CNT_W-1:0]     entry_count
);
  import bhpq_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(status))
    else $error("stalled result changed");

  // One transaction in flight: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a command while one is in flight");

  // Errors remove nothing
  a_err_no_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> removed_value == '0)
    else $error("error result carries a removed value");

  // Empty flag agrees with count and top
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (heap_empty == (entry_count == '0)) && (!heap_empty || top_value == '0))
    else $error("empty flag inconsistent with count or top");

  // A pop on an empty heap only ever reports an empty heap
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> heap_empty)
    else $error("empty-heap error with entries held");

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .removed_value (out_ch.removed_value),
  .top_value     (out_ch.top_value),
  .heap_empty    (out_ch.heap_empty),
  .entry_count   (out_ch.entry_count)
);

### tb/sv/binary_heap_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_tb
// Drives push and pop transactions into the heap under random source gaps and
// sink stalls, switches between max-heap and min-heap ordering between
// phases, and checks every result against a heap predictor kept in step with
// each accepted command.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam logic MODE_MIN     = 1'b1;
  localparam int   RANDOM_ITEMS = 1150;
  localparam int   DRAIN_CYCLES = 24;
  localparam int   CYCLE_LIMIT  = 500000;
  localparam int   REPORT_MAX   = 10;

  // One heap result as seen on the output channel
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed;
    logic signed [DATA_W-1:0] top;
    logic                     empty;
    logic [OUT_CNT_W-1:0]     count;
  } heap_result_t;

  // Heap predictor and store of results still owed by the block
  class heap_scoreboard;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    int unsigned              fill;
    logic                     mode;
    heap_result_t             owed [$];
    int unsigned              errors;

    function new();
      fill   = 0;
      mode   = MODE_MAX;
      errors = 0;
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // True when a belongs above b under the current ordering
    function bit ranks_above(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      return (mode == MODE_MAX) ? (a > b) : (a < b);
    endfunction

    function void swap(int unsigned x, int unsigned y);
      logic signed [DATA_W-1:0] t;
      t          = entries[x];
      entries[x] = entries[y];
      entries[y] = t;
    endfunction

    // Apply one accepted command and queue the result it owes
    function void note_command(logic cmd, logic signed [DATA_W-1:0] val);
      heap_result_t res;
      int unsigned  pos;
      int unsigned  best;
      int unsigned  kid;
      res = '0;
      res.status = ST_OK;
      if (cmd == CMD_PUSH) begin
        if (fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // append, then bubble toward the root
          entries[fill] = val;
          pos = fill;
          fill++;
          while (pos > 0 && ranks_above(entries[pos], entries[(pos - 1) / 2])) begin
            swap(pos, (pos - 1) / 2);
            pos = (pos - 1) / 2;
          end
        end
      end else begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // move the last entry to the root, then sink it
          res.removed = entries[0];
          fill--;
          entries[0] = entries[fill];
          pos = 0;
          while (pos < fill) begin
            best = pos;
            kid  = 2 * pos + 1;
            if (kid < fill && ranks_above(entries[kid], entries[best])) best = kid;
            kid  = 2 * pos + 2;
            if (kid < fill && ranks_above(entries[kid], entries[best])) best = kid;
            if (best == pos) break;
            swap(pos, best);
            pos = best;
          end
        end
      end
      res.top   = (fill != 0) ? entries[0] : '0;
      res.empty = (fill == 0);
      res.count = fill[OUT_CNT_W-1:0];
      owed = {owed, res};
    endfunction

    // Compare one accepted result against the oldest owed one
    function void check_result(heap_result_t got);
      heap_result_t exp;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: status=%0d removed=%0d top=%0d empty=%0b count=%0d",
                   got.status, got.removed, got.top, got.empty, got.count);
        return;
      end
      exp = owed.pop_front();
      if (got.status !== exp.status || got.removed !== exp.removed ||
          got.top !== exp.top || got.empty !== exp.empty || got.count !== exp.count) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("result error: expected status=%0d removed=%0d top=%0d empty=%0b count=%0d",
                   exp.status, exp.removed, exp.top, exp.empty, exp.count);
          $display("              actual   status=%0d removed=%0d top=%0d empty=%0b count=%0d",
                   got.status, got.removed, got.top, got.empty, got.count);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  int unsigned cycle_count = 0;
  int unsigned calm_tx;
  int unsigned calm_rx;

  heap_scoreboard sb = new();

  bhpq_in_if  in_ch();
  bhpq_out_if out_ch();

  binary_heap_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample mode writes and transactions on both channels; bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_heap_priority_queue: mismatch");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) sb.set_mode(cfg_wr_data);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.status, out_ch.removed_value, out_ch.top_value,
                          out_ch.heap_empty, out_ch.entry_count});
      if (in_ch.valid && in_ch.ready) sb.note_command(in_ch.command, in_ch.value);
    end
  end

  // Draw an idle count; now and then start a stretch with no idling at all
  function automatic int unsigned draw_wait(ref int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(20, 60);
    return $urandom_range(0, 17);
  endfunction

  // Mostly full-range values, with duplicates and extremes mixed in
  function automatic logic signed [DATA_W-1:0] draw_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1: v = $signed($urandom_range(0, 8)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Hold off, then present one command until the transaction completes
  task automatic send_command(input logic cmd, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = draw_wait(calm_tx);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= val;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Drop valid, wait for every owed result, then write the ordering mode
  task automatic write_mode(input logic m);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result sink: stall at random before taking each transaction
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    calm_rx      = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(calm_rx);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned push_pct;
    int unsigned span;
    logic        cmd;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_PUSH;
    in_ch.value   = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = MODE_MAX;
    rst_n         = 1'b0;
    calm_tx       = 0;
    sent          = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Max-heap: empty pop, extremes in, drain past empty
    write_mode(MODE_MAX);
    send_command(CMD_POP, 32'sh7fff_ffff);
    send_command(CMD_PUSH, 32'sh8000_0000);
    send_command(CMD_PUSH, 32'sh7fff_ffff);
    send_command(CMD_PUSH, 32'sd0);
    send_command(CMD_PUSH, -32'sd1);
    send_command(CMD_PUSH, 32'sd1);
    repeat (6) send_command(CMD_POP, $urandom);

    // Min-heap, then flip to max-heap with entries still held
    write_mode(MODE_MIN);
    send_command(CMD_PUSH, 32'sd5);
    send_command(CMD_PUSH, -32'sd5);
    send_command(CMD_PUSH, 32'sh7fff_ffff);
    send_command(CMD_PUSH, 32'sh8000_0000);
    write_mode(MODE_MAX);
    send_command(CMD_PUSH, 32'sd7);
    repeat (6) send_command(CMD_POP, $urandom);

    // Random phases: fill toward full, drain toward empty, or mix
    while (sent < RANDOM_ITEMS) begin
      write_mode(1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 55;
      endcase
      span = $urandom_range(40, 120);
      if (span > RANDOM_ITEMS - sent) span = RANDOM_ITEMS - sent;
      repeat (span) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        send_command(cmd, draw_value());
        sent++;
      end
    end

    // Drain and report
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("binary_heap_priority_queue: match");
    end else begin
      $display("binary_heap_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
